FILE: design/stepper_step_pulse_generator_unit_macros.svh
// assertion helpers used by sppg_exec
`ifndef STEPPER_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sppg assertion failed");

// next-cycle implication, checked outside reset
`define SPPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sppg assertion failed");

`endif

FILE: design/sppg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sppg_pkg;

  localparam int STEP_COUNT_BITS = 24;
  localparam int HALF_STEPS_W = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;

  typedef logic [STEP_COUNT_BITS-1:0] step_cnt_t;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SET_DIR = 3'd4,
    CMD_SET_POS = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ERR   = 2'd1,
    STATUS_PARAM = 2'd2,
    STATUS_INTR  = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_POS_MIN   = 2'd1,
    REG_POS_MAX   = 2'd2,
    REG_DIR_REV   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic [15:0]              timer_now;
    logic [15:0]              timer_reload;
    logic [HALF_STEPS_W-1:0]  half_steps;
    logic                     dir_value;
    logic signed [31:0]       pos_load;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               step_pin;
    logic               dir_pin;
    logic               sleep_pin;
    logic               running;
    logic signed [31:0] position_out;
  } res_t;

  typedef struct packed {
    logic held;
    logic adv;
  } flow_t;

  // fit the half-step field to the step counter width
  function automatic step_cnt_t to_steps(input logic [HALF_STEPS_W-1:0] h);
    logic [STEP_COUNT_BITS+HALF_STEPS_W-1:0] wide;
    wide = {{STEP_COUNT_BITS{1'b0}}, h};
    return wide[STEP_COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/sppg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sppg_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [15:0]        timer_now;
  logic [15:0]        timer_reload;
  logic [23:0]        half_steps;
  logic               dir_value;
  logic signed [31:0] pos_load;

  modport source (
    output valid, cmd, timer_now, timer_reload, half_steps, dir_value, pos_load,
    input  ready
  );
  modport sink (
    input  valid, cmd, timer_now, timer_reload, half_steps, dir_value, pos_load,
    output ready
  );
endinterface

interface sppg_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               step_pin;
  logic               dir_pin;
  logic               sleep_pin;
  logic               running;
  logic signed [31:0] position_out;

  modport source (
    output valid, status, step_pin, dir_pin, sleep_pin, running, position_out,
    input  ready
  );
  modport sink (
    input  valid, status, step_pin, dir_pin, sleep_pin, running, position_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/stepper_step_pulse_generator_unit.sv
// a result is offered once its input transaction has passed the input register and then the result register
// throughput: one transaction per cycle while the result side keeps taking results
// input register and result register let a new transaction in while a result waits
// reset: synchronous, active high; motion state cleared, driver asleep, step size 1
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_pulse_generator_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [sppg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sppg_pkg::CFG_DATA_W-1:0]    cfg_data,
  sppg_item_if.sink                               item,
  sppg_result_if.source                           result
);
  import sppg_pkg::*;

  flow_t flow;
  item_t held_item;
  res_t  res;
  logic  out_free;

  sppg_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .out_free  (out_free),
    .flow      (flow),
    .held_item (held_item)
  );

  sppg_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flow      (flow),
    .item      (held_item),
    .res       (res)
  );

  sppg_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .flow     (flow),
    .res_in   (res),
    .result   (result),
    .out_free (out_free)
  );

endmodule

`default_nettype wire

FILE: design/sppg_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sppg_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  sppg_item_if.sink           item,
  input  wire logic           out_free,
  output sppg_pkg::flow_t     flow,
  output sppg_pkg::item_t     held_item
);
  import sppg_pkg::*;

  logic held;
  logic adv;
  logic take;

  assign adv  = held && out_free;
  assign take = item.valid && item.ready;
  assign item.ready = !held || adv;

  assign flow.held = held;
  assign flow.adv  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (adv) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item.cmd          <= item.cmd;
      held_item.timer_now    <= item.timer_now;
      held_item.timer_reload <= item.timer_reload;
      held_item.half_steps   <= item.half_steps;
      held_item.dir_value    <= item.dir_value;
      held_item.pos_load     <= item.pos_load;
    end
  end

endmodule

`default_nettype wire

FILE: design/sppg_exec.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_step_pulse_generator_unit_macros.svh"

module sppg_exec (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [sppg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sppg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire sppg_pkg::flow_t                    flow,
  input  wire sppg_pkg::item_t                    item,
  output sppg_pkg::res_t                          res
);
  import sppg_pkg::*;

  // configuration
  logic [15:0]        step_units;
  logic signed [31:0] position_min;
  logic signed [31:0] position_max;
  logic               dir_reversed;

  // motion state
  logic [15:0] countdown,      countdown_next;
  logic [15:0] reload_value,   reload_value_next;
  step_cnt_t   steps_left,     steps_left_next;
  logic        step_level,     step_level_next;
  logic        is_running,     is_running_next;
  logic        is_asleep,      is_asleep_next;
  logic        direction_flag, direction_flag_next;
  logic [31:0] position,       position_next;

  step_cnt_t   steps_dec;
  logic [31:0] step_ext;
  status_t     status;

  assign step_ext = {16'd0, step_units};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_units   <= 16'd1;
      position_min <= '0;
      position_max <= '0;
      dir_reversed <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_STEP_SIZE: step_units   <= cfg_data[15:0];
        REG_POS_MIN:   position_min <= cfg_data[31:0];
        REG_POS_MAX:   position_max <= cfg_data[31:0];
        REG_DIR_REV:   dir_reversed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    countdown_next      = countdown;
    reload_value_next   = reload_value;
    steps_left_next     = steps_left;
    step_level_next     = step_level;
    is_running_next     = is_running;
    is_asleep_next      = is_asleep;
    direction_flag_next = direction_flag;
    position_next       = position;
    status              = STATUS_OK;
    steps_dec           = (steps_left == '0) ? '0 : steps_left - 1'b1;

    case (cmd_t'(item.cmd))
      CMD_TICK: begin
        if (!is_running || is_asleep) begin
          status = STATUS_ERR;
        end else if (countdown <= 16'd1) begin
          countdown_next  = reload_value;
          steps_left_next = steps_dec;
          if (steps_dec == '0) begin
            is_running_next = 1'b0;
            is_asleep_next  = 1'b1;
          end
          if (step_level) begin
            step_level_next = 1'b0;
          end else begin
            step_level_next = 1'b1;
            position_next   = direction_flag ? position + step_ext : position - step_ext;
          end
        end else begin
          countdown_next = countdown - 16'd1;
        end
      end
      CMD_LOAD: begin
        countdown_next    = item.timer_now;
        reload_value_next = item.timer_reload;
        steps_left_next   = to_steps(item.half_steps);
      end
      CMD_START: begin
        if (countdown == 16'd0 || reload_value == 16'd0 || steps_left == '0) begin
          status = STATUS_PARAM;
        end else if (step_level) begin
          status = STATUS_ERR;
        end else begin
          is_asleep_next  = 1'b0;
          is_running_next = 1'b1;
        end
      end
      CMD_STOP: begin
        is_running_next = 1'b0;
        is_asleep_next  = 1'b1;
        step_level_next = 1'b0;
        status          = (steps_left != '0) ? STATUS_INTR : STATUS_OK;
      end
      CMD_SET_DIR: begin
        direction_flag_next = item.dir_value;
      end
      CMD_SET_POS: begin
        if (item.pos_load < position_min || position_max < item.pos_load) begin
          status = STATUS_PARAM;
        end else begin
          position_next = item.pos_load;
        end
      end
      default: begin
        status = STATUS_ERR;
      end
    endcase

    res.status       = status;
    res.step_pin     = step_level_next;
    res.dir_pin      = direction_flag_next ^ dir_reversed;
    res.sleep_pin    = !is_asleep_next;
    res.running      = is_running_next;
    res.position_out = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown      <= '0;
      reload_value   <= '0;
      steps_left     <= '0;
      step_level     <= 1'b0;
      is_running     <= 1'b0;
      is_asleep      <= 1'b1;
      direction_flag <= 1'b0;
      position       <= '0;
    end else if (flow.adv) begin
      countdown      <= countdown_next;
      reload_value   <= reload_value_next;
      steps_left     <= steps_left_next;
      step_level     <= step_level_next;
      is_running     <= is_running_next;
      is_asleep      <= is_asleep_next;
      direction_flag <= direction_flag_next;
      position       <= position_next;
    end
  end

  `SPPG_ASSERT_IMPL(a_run_awake, is_running, !is_asleep)
  `SPPG_ASSERT_NEXT(a_stop_clears, flow.adv && item.cmd == CMD_STOP, !is_running && !step_level)
  `SPPG_ASSERT_NEXT(a_idle_tick_holds, flow.adv && item.cmd == CMD_TICK && !is_running, $stable(position) && $stable(steps_left))
  `SPPG_ASSERT_NEXT(a_no_adv_holds, !flow.adv, $stable(position) && $stable(steps_left) && $stable(step_level))

endmodule

`default_nettype wire

FILE: design/sppg_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sppg_out_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sppg_pkg::flow_t flow,
  input  wire sppg_pkg::res_t  res_in,
  sppg_result_if.source     result,
  output logic              out_free
);
  import sppg_pkg::*;

  logic   valid;
  res_t   data;

  assign out_free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (flow.adv) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.adv) begin
      data <= res_in;
    end
  end

  assign result.valid        = valid;
  assign result.status       = data.status;
  assign result.step_pin     = data.step_pin;
  assign result.dir_pin      = data.dir_pin;
  assign result.sleep_pin    = data.sleep_pin;
  assign result.running      = data.running;
  assign result.position_out = data.position_out;

endmodule

`default_nettype wire
